// ----- hdl/ktts_pkg.sv -----
// shared types, constants and codes for the two-state tracker
`default_nettype none
package ktts_pkg;

    localparam int DataW     = 64;
    localparam int RegIdxW   = 3;
    localparam int FracBitsDefault = 32;

    // register indexes
    typedef enum logic [RegIdxW-1:0] {
        REG_STEP_TIME = 3'd0,
        REG_QPP       = 3'd1,
        REG_QPV       = 3'd2,
        REG_QVV       = 3'd3,
        REG_RPP       = 3'd4,
        REG_RPV       = 3'd5,
        REG_RVV       = 3'd6,
        REG_NONE      = 3'd7
    } reg_idx_t;

    // arithmetic unit operations
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        AU_IDLE = 2'd0,
        AU_RUN  = 2'd1,
        AU_DONE = 2'd2
    } au_state_t;

    typedef enum logic [2:0] {
        SQ_IDLE = 3'd0,
        SQ_EXEC = 3'd1,
        SQ_WAIT = 3'd2,
        SQ_OUT  = 3'd3,
        SQ_HOLD = 3'd4
    } sq_state_t;

    // request to the serial arithmetic unit
    typedef struct packed {
        logic              start;
        op_t               op;
    } au_req_t;

    // ops used in the microprogram
    typedef enum logic [3:0] {
        U_MUL  = 4'd0,
        U_DIV  = 4'd1,
        U_SQRT = 4'd2,
        U_ADD  = 4'd3,
        U_SUB  = 4'd4,
        U_PIV  = 4'd5,
        U_MOV  = 4'd6,
        U_SKIP = 4'd7,
        U_END  = 4'd8
    } uop_t;

    localparam int RegFileN = 32;
    localparam int RfW = 5;

    typedef struct packed {
        uop_t           op;
        logic [RfW-1:0] dst;
        logic [RfW-1:0] a;
        logic [RfW-1:0] b;
    } uinst_t;

    // register file slots
    localparam logic [RfW-1:0] R_ZERO = 5'd0,  R_ONE = 5'd1,  R_DT = 5'd2,
        R_QPP = 5'd3, R_QPV = 5'd4, R_QVV = 5'd5, R_RPP = 5'd6, R_RPV = 5'd7,
        R_RVV = 5'd8, R_X0 = 5'd9, R_X1 = 5'd10, R_P00 = 5'd11, R_P01 = 5'd12,
        R_P10 = 5'd13, R_P11 = 5'd14, R_ACC = 5'd15, R_PM = 5'd16, R_VM = 5'd17,
        R_T0 = 5'd18, R_T1 = 5'd19, R_T2 = 5'd20, R_T3 = 5'd21, R_T4 = 5'd22,
        R_T5 = 5'd23, R_T6 = 5'd24, R_T7 = 5'd25, R_T8 = 5'd26, R_T9 = 5'd27,
        R_TA = 5'd28, R_TB = 5'd29, R_TC = 5'd30, R_TD = 5'd31;

    localparam int ProgN = 128;
    localparam int PcW = 7;

    function automatic uinst_t ui(uop_t o, logic [RfW-1:0] d, logic [RfW-1:0] a,
                                  logic [RfW-1:0] b);
        uinst_t r;
        r.op = o; r.dst = d; r.a = a; r.b = b;
        return r;
    endfunction

    // microprogram: one step of the filter
    function automatic uinst_t prog(logic [PcW-1:0] pc);
        uinst_t r;
        r = ui(U_END, R_ZERO, R_ZERO, R_ZERO);
        case (pc)
            // state prediction
            7'd0:  r = ui(U_MUL, R_T0, R_DT, R_X1);
            7'd1:  r = ui(U_ADD, R_X0, R_X0, R_T0);
            7'd2:  r = ui(U_MUL, R_T0, R_DT, R_ACC);
            7'd3:  r = ui(U_ADD, R_X1, R_X1, R_T0);
            // A = F P : row0 = p0j + dt*p1j (as 1*p0j + dt*p1j), row1 = 0*p0j + 1*p1j
            7'd4:  r = ui(U_MUL, R_T0, R_ONE, R_P00);
            7'd5:  r = ui(U_MUL, R_T1, R_DT, R_P10);
            7'd6:  r = ui(U_ADD, R_T0, R_T0, R_T1);   // a00
            7'd7:  r = ui(U_MUL, R_T1, R_ONE, R_P01);
            7'd8:  r = ui(U_MUL, R_T2, R_DT, R_P11);
            7'd9:  r = ui(U_ADD, R_T1, R_T1, R_T2);   // a01
            7'd10: r = ui(U_MUL, R_T2, R_ZERO, R_P00);
            7'd11: r = ui(U_MUL, R_T3, R_ONE, R_P10);
            7'd12: r = ui(U_ADD, R_T2, R_T2, R_T3);   // a10
            7'd13: r = ui(U_MUL, R_T3, R_ZERO, R_P01);
            7'd14: r = ui(U_MUL, R_T4, R_ONE, R_P11);
            7'd15: r = ui(U_ADD, R_T3, R_T3, R_T4);   // a11
            // P = A F' + Q ; F' = [[1,0],[dt,1]]
            7'd16: r = ui(U_MUL, R_T4, R_T0, R_ONE);
            7'd17: r = ui(U_MUL, R_T5, R_T1, R_DT);
            7'd18: r = ui(U_ADD, R_T4, R_T4, R_T5);
            7'd19: r = ui(U_ADD, R_P00, R_T4, R_QPP);
            7'd20: r = ui(U_MUL, R_T4, R_T0, R_ZERO);
            7'd21: r = ui(U_MUL, R_T5, R_T1, R_ONE);
            7'd22: r = ui(U_ADD, R_T4, R_T4, R_T5);
            7'd23: r = ui(U_ADD, R_P01, R_T4, R_QPV);
            7'd24: r = ui(U_MUL, R_T4, R_T2, R_ONE);
            7'd25: r = ui(U_MUL, R_T5, R_T3, R_DT);
            7'd26: r = ui(U_ADD, R_T4, R_T4, R_T5);
            7'd27: r = ui(U_ADD, R_P10, R_T4, R_QPV);
            7'd28: r = ui(U_MUL, R_T4, R_T2, R_ZERO);
            7'd29: r = ui(U_MUL, R_T5, R_T3, R_ONE);
            7'd30: r = ui(U_ADD, R_T4, R_T4, R_T5);
            7'd31: r = ui(U_ADD, R_P11, R_T4, R_QVV);
            7'd32: r = ui(U_SKIP, R_ZERO, R_ZERO, R_ZERO);
            // innovation covariance and cholesky
            7'd33: r = ui(U_ADD, R_T0, R_P00, R_RPP);  // s00
            7'd34: r = ui(U_ADD, R_T1, R_P01, R_RPV);  // s01
            7'd35: r = ui(U_ADD, R_T2, R_P11, R_RVV);  // s11
            7'd36: r = ui(U_SQRT, R_T3, R_T0, R_ZERO); // l00
            7'd37: r = ui(U_PIV, R_T4, R_T3, R_ZERO);  // c0
            7'd38: r = ui(U_DIV, R_T5, R_T1, R_T4);    // l10
            7'd39: r = ui(U_MUL, R_T6, R_T5, R_T5);
            7'd40: r = ui(U_SUB, R_T6, R_T2, R_T6);
            7'd41: r = ui(U_SQRT, R_T6, R_T6, R_ZERO); // l11
            7'd42: r = ui(U_PIV, R_T6, R_T6, R_ZERO);  // c1
            7'd43: r = ui(U_DIV, R_T7, R_ONE, R_T6);
            7'd44: r = ui(U_DIV, R_T7, R_T7, R_T6);    // inv11
            7'd45: r = ui(U_MUL, R_T8, R_T5, R_T7);
            7'd46: r = ui(U_SUB, R_T8, R_ZERO, R_T8);
            7'd47: r = ui(U_DIV, R_T8, R_T8, R_T4);    // inv01 = inv10
            7'd48: r = ui(U_DIV, R_T9, R_ONE, R_T4);
            7'd49: r = ui(U_MUL, R_TA, R_T5, R_T8);
            7'd50: r = ui(U_SUB, R_T9, R_T9, R_TA);
            7'd51: r = ui(U_DIV, R_T9, R_T9, R_T4);    // inv00
            // K = P inv : T0=k00 T1=k01 T2=k10 T3=k11
            7'd52: r = ui(U_MUL, R_T0, R_P00, R_T9);
            7'd53: r = ui(U_MUL, R_TA, R_P01, R_T8);
            7'd54: r = ui(U_ADD, R_T0, R_T0, R_TA);
            7'd55: r = ui(U_MUL, R_T1, R_P00, R_T8);
            7'd56: r = ui(U_MUL, R_TA, R_P01, R_T7);
            7'd57: r = ui(U_ADD, R_T1, R_T1, R_TA);
            7'd58: r = ui(U_MUL, R_T2, R_P10, R_T9);
            7'd59: r = ui(U_MUL, R_TA, R_P11, R_T8);
            7'd60: r = ui(U_ADD, R_T2, R_T2, R_TA);
            7'd61: r = ui(U_MUL, R_T3, R_P10, R_T8);
            7'd62: r = ui(U_MUL, R_TA, R_P11, R_T7);
            7'd63: r = ui(U_ADD, R_T3, R_T3, R_TA);
            // I - K : T4..T7
            7'd64: r = ui(U_SUB, R_T4, R_ONE, R_T0);
            7'd65: r = ui(U_SUB, R_T5, R_ZERO, R_T1);
            7'd66: r = ui(U_SUB, R_T6, R_ZERO, R_T2);
            7'd67: r = ui(U_SUB, R_T7, R_ONE, R_T3);
            // innovation
            7'd68: r = ui(U_SUB, R_T8, R_PM, R_X0);
            7'd69: r = ui(U_SUB, R_T9, R_VM, R_X1);
            // P = (I-K) P into TA..TD
            7'd70: r = ui(U_MUL, R_TA, R_T4, R_P00);
            7'd71: r = ui(U_MUL, R_ACC, R_T5, R_P10);
            7'd72: r = ui(U_ADD, R_TA, R_TA, R_ACC);
            7'd73: r = ui(U_MUL, R_TB, R_T4, R_P01);
            7'd74: r = ui(U_MUL, R_ACC, R_T5, R_P11);
            7'd75: r = ui(U_ADD, R_TB, R_TB, R_ACC);
            7'd76: r = ui(U_MUL, R_TC, R_T6, R_P00);
            7'd77: r = ui(U_MUL, R_ACC, R_T7, R_P10);
            7'd78: r = ui(U_ADD, R_TC, R_TC, R_ACC);
            7'd79: r = ui(U_MUL, R_TD, R_T6, R_P01);
            7'd80: r = ui(U_MUL, R_ACC, R_T7, R_P11);
            7'd81: r = ui(U_ADD, R_TD, R_TD, R_ACC);
            7'd82: r = ui(U_MOV, R_P00, R_TA, R_ZERO);
            7'd83: r = ui(U_MOV, R_P01, R_TB, R_ZERO);
            7'd84: r = ui(U_MOV, R_P10, R_TC, R_ZERO);
            7'd85: r = ui(U_MOV, R_P11, R_TD, R_ZERO);
            // estimate update
            7'd86: r = ui(U_MUL, R_TA, R_T0, R_T8);
            7'd87: r = ui(U_MUL, R_TB, R_T1, R_T9);
            7'd88: r = ui(U_ADD, R_TA, R_TA, R_TB);
            7'd89: r = ui(U_ADD, R_X0, R_X0, R_TA);
            7'd90: r = ui(U_MUL, R_TA, R_T2, R_T8);
            7'd91: r = ui(U_MUL, R_TB, R_T3, R_T9);
            7'd92: r = ui(U_ADD, R_TA, R_TA, R_TB);
            7'd93: r = ui(U_ADD, R_X1, R_X1, R_TA);
            default: r = ui(U_END, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/kalman_tracker_two_state.sv -----
// top level: config registers, microcoded sequencer and output stage
//
// channel  | handshake           | payload
// in       | in_valid/in_ready   | accel, pos_meas, vel_meas, skip_update
// out      | out_valid/out_ready | pos_out, vel_out, cov_pp, cov_pv, cov_vp, cov_vv
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item runs 49 long ops on the shared serial unit plus 45 short ops; a
// predict-only step stops at the skip op, right after the covariance prediction.
// reset loads the register defaults and the initial state at once.
// a result waits in the output register; the next beat is taken while it waits,
// and the sequencer holds before writing a new result until it is taken.
`default_nettype none
module kalman_tracker_two_state
    import ktts_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [63:0]  accel,
    input  wire logic signed [63:0]  pos_meas,
    input  wire logic signed [63:0]  vel_meas,
    input  wire logic                skip_update,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [63:0]       pos_out,
    output logic signed [63:0]       vel_out,
    output logic signed [63:0]       cov_pp,
    output logic signed [63:0]       cov_pv,
    output logic signed [63:0]       cov_vp,
    output logic signed [63:0]       cov_vv,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [RegIdxW-1:0]  cfg_index,
    input  wire logic [63:0]         cfg_data
);
    localparam logic [DataW-1:0] One  = DataW'(1) << FRAC_BITS;
    localparam logic [DataW-1:0] Eps  = DataW'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic [DataW-1:0] DtR  = DataW'(((64'd1 << FRAC_BITS) * 64'd25 + 64'd500) / 64'd1000);
    localparam logic [DataW-1:0] QppR = DataW'(((64'd1 << FRAC_BITS) * 64'd625 + 64'd50000000000)
                                               / 64'd100000000000);
    localparam logic [DataW-1:0] QvvR = DataW'(((64'd1 << FRAC_BITS) * 64'd5) / 64'd32);
    localparam logic [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

    logic [DataW-1:0] rf_reg [RegFileN];
    sq_state_t        state_reg, state_next;
    logic [PcW-1:0]   pc_reg, pc_next;
    logic             skip_reg;
    logic             out_valid_reg;
    logic [DataW-1:0] o_reg [6];
    uinst_t           ins;
    au_req_t          req;
    logic             au_done;
    logic [DataW-1:0] au_res;
    logic [DataW-1:0] opa, opb;

    assign ins = prog(pc_reg);
    assign opa = rf_reg[ins.a];
    assign opb = rf_reg[ins.b];

    ktts_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .a      (opa),
        .b      (opb),
        .done   (au_done),
        .result (au_res)
    );

    // saturating add / sub
    logic [DataW:0]   sum_w;
    logic [DataW-1:0] alu_simple;
    logic [DataW-1:0] nb;
    always_comb
    begin
        nb    = (ins.op == U_SUB) ? ~opb : opb;
        sum_w = {opa[DataW-1], opa} + {nb[DataW-1], nb} + ((ins.op == U_SUB) ? 1'b1 : 1'b0);
        alu_simple = opa;
        case (ins.op)
            U_ADD, U_SUB:
                alu_simple = (sum_w[DataW] != sum_w[DataW-1]) ?
                             (sum_w[DataW] ? SMin : SMax) : sum_w[DataW-1:0];
            U_PIV:
                if (!opa[DataW-1])
                    alu_simple = (opa < Eps) ? Eps : opa;
                else
                    alu_simple = ($signed(opa) > $signed(-Eps)) ? (~Eps + 1'b1) : opa;
            default: alu_simple = opa;
        endcase
    end

    logic is_long;
    assign is_long = (ins.op == U_MUL) || (ins.op == U_DIV) || (ins.op == U_SQRT);

    always_comb
    begin
        req.start = 1'b0;
        req.op    = OP_NOP;
        if (state_reg == SQ_EXEC && is_long)
        begin
            req.start = 1'b1;
            req.op    = (ins.op == U_MUL) ? OP_MUL : (ins.op == U_DIV) ? OP_DIV : OP_SQRT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            SQ_IDLE:
                if (in_valid)
                begin
                    state_next = SQ_EXEC;
                    pc_next    = '0;
                end
            SQ_EXEC:
                if (ins.op == U_END)
                    state_next = SQ_HOLD;
                else if (is_long)
                    state_next = SQ_WAIT;
                else if (ins.op == U_SKIP && skip_reg)
                    state_next = SQ_HOLD;
                else
                    pc_next = pc_reg + 1'b1;
            SQ_WAIT:
                if (au_done)
                begin
                    state_next = SQ_EXEC;
                    pc_next    = pc_reg + 1'b1;
                end
            SQ_HOLD:
                if (!out_valid_reg || out_ready)
                    state_next = SQ_OUT;
            SQ_OUT:
                state_next = SQ_IDLE;
            default: state_next = SQ_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == SQ_IDLE);
    assign cfg_ready = (state_reg == SQ_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RegFileN; i++) rf_reg[i] <= '0;
            rf_reg[R_ONE] <= One;
            rf_reg[R_DT]  <= DtR;
            rf_reg[R_QPP] <= QppR;
            rf_reg[R_QVV] <= QvvR;
            rf_reg[R_RPP] <= DataW'(900) << FRAC_BITS;
            rf_reg[R_RVV] <= DataW'(25) << FRAC_BITS;
            rf_reg[R_P00] <= DataW'(1800) << FRAC_BITS;
            rf_reg[R_P11] <= DataW'(100) << FRAC_BITS;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (state_reg == SQ_OUT) out_valid_reg <= 1'b1;
            if (in_valid && in_ready)
            begin
                rf_reg[R_ACC] <= accel;
                rf_reg[R_PM]  <= pos_meas;
                rf_reg[R_VM]  <= vel_meas;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_STEP_TIME: rf_reg[R_DT]  <= {1'b0, cfg_data[62:0]};
                    REG_QPP:       rf_reg[R_QPP] <= {1'b0, cfg_data[62:0]};
                    REG_QPV:       rf_reg[R_QPV] <= cfg_data;
                    REG_QVV:       rf_reg[R_QVV] <= {1'b0, cfg_data[62:0]};
                    REG_RPP:       rf_reg[R_RPP] <= {1'b0, cfg_data[62:0]};
                    REG_RPV:       rf_reg[R_RPV] <= cfg_data;
                    REG_RVV:       rf_reg[R_RVV] <= {1'b0, cfg_data[62:0]};
                    default: ;
                endcase
            end
            if (state_reg == SQ_EXEC && !is_long && ins.op != U_END && ins.op != U_SKIP)
                rf_reg[ins.dst] <= alu_simple;
            if (state_reg == SQ_WAIT && au_done)
                rf_reg[ins.dst] <= au_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) skip_reg <= skip_update;
        if (state_reg == SQ_OUT)
        begin
            o_reg[0] <= rf_reg[R_X0];
            o_reg[1] <= rf_reg[R_X1];
            o_reg[2] <= rf_reg[R_P00];
            o_reg[3] <= rf_reg[R_P01];
            o_reg[4] <= rf_reg[R_P10];
            o_reg[5] <= rf_reg[R_P11];
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_out   = o_reg[0];
    assign vel_out   = o_reg[1];
    assign cov_pp    = o_reg[2];
    assign cov_pv    = o_reg[3];
    assign cov_vp    = o_reg[4];
    assign cov_vv    = o_reg[5];

    property p_out_held;
        @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid;
    endproperty
    a_out_held: assert property (p_out_held) else $error("result beat dropped");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == SQ_OUT) |-> ($past(!out_valid_reg) || $past(out_ready));
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

    property p_wait_long;
        @(posedge clk) disable iff (!rst_n) (state_reg == SQ_WAIT) |-> is_long;
    endproperty
    a_wait_long: assert property (p_wait_long) else $error("wait on a short op");

endmodule
`default_nettype wire

// ----- hdl/ktts_alu.sv -----
// bit-serial multiply, divide and square root on Q-format magnitudes
`default_nettype none
module ktts_alu
    import ktts_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire au_req_t           req,
    input  wire logic [DataW-1:0]  a,
    input  wire logic [DataW-1:0]  b,
    output logic                   done,
    output logic [DataW-1:0]       result
);
    localparam int NumW  = 2 * DataW;
    localparam int CntW  = $clog2(NumW + 1);
    localparam logic [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

    au_state_t state_reg, state_next;
    op_t       op_reg;
    logic [CntW-1:0]   cnt_reg;
    logic              neg_reg;
    logic [DataW-1:0]  ma_reg, mb_reg;
    logic [NumW-1:0]   acc_reg;      // product accumulator or dividend/radicand shifter
    logic [NumW-1:0]   quo_reg;      // quotient bits
    logic [DataW+1:0]  rem_reg;      // remainder (one bit margin for sqrt trial)
    logic [DataW-1:0]  root_reg;

    logic [DataW-1:0] mag_a, mag_b;
    assign mag_a = a[DataW-1] ? (~a + 1'b1) : a;
    assign mag_b = b[DataW-1] ? (~b + 1'b1) : b;

    // shift-add multiply step: one multiplier bit per cycle, carry kept
    logic [NumW:0] mul_add;
    assign mul_add = mb_reg[0] ? ({1'b0, acc_reg} + {1'b0, ma_reg, {DataW{1'b0}}}) :
                     {1'b0, acc_reg};

    // restoring divide step
    logic [DataW:0]  div_trial;
    logic [DataW+1:0] div_sh;
    assign div_sh    = {rem_reg[DataW:0], acc_reg[NumW-1]};
    assign div_trial = div_sh[DataW:0] - {1'b0, mb_reg};

    // digit-by-digit root step, two radicand bits per cycle
    logic [DataW+1:0] sq_sh, sq_trial;
    assign sq_sh    = {rem_reg[DataW-1:0], acc_reg[NumW-1 -: 2]};
    assign sq_trial = sq_sh - {root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AU_IDLE: if (req.start) state_next = AU_RUN;
            AU_RUN:  if (cnt_reg == '0) state_next = AU_DONE;
            AU_DONE: state_next = AU_IDLE;
            default: state_next = AU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    logic [NumW-1:0]  prod_r;
    logic [DataW-1:0] prod_hi_chk;
    logic [NumW:0]    qround;
    logic [DataW-1:0] sat_mag_v;
    logic             ovf_v;

    always_comb
    begin
        prod_r      = acc_reg + (NumW'(1) << (FRAC_BITS - 1));
        prod_hi_chk = prod_r[NumW-1:DataW];
        ovf_v       = 1'b0;
        sat_mag_v   = '0;
        qround      = '0;
        case (op_reg)
            OP_MUL:
            begin
                ovf_v = (acc_reg[NumW-1:DataW+FRAC_BITS] != '0) || (prod_r < acc_reg) ||
                        ((prod_hi_chk >> FRAC_BITS) != '0);
                sat_mag_v = DataW'(prod_r >> FRAC_BITS);
            end
            OP_DIV:
            begin
                qround = {1'b0, quo_reg} +
                         (({1'b0, rem_reg[DataW-1:0]} >= ({1'b0, mb_reg} - {1'b0, rem_reg[DataW-1:0]}))
                          ? (NumW+1)'(1) : '0);
                ovf_v     = qround[NumW:DataW] != '0;
                sat_mag_v = qround[DataW-1:0];
            end
            default:
            begin
                ovf_v     = 1'b0;
                sat_mag_v = root_reg;
            end
        endcase
    end

    logic [DataW-1:0] signed_res;
    always_comb
    begin
        if (neg_reg)
            signed_res = (ovf_v || sat_mag_v[DataW-1]) ? SMin : (~sat_mag_v + 1'b1);
        else
            signed_res = (ovf_v || sat_mag_v[DataW-1]) ? SMax : sat_mag_v;
    end

    // result is valid in the done beat itself
    logic [DataW-1:0] res_val;
    always_comb
    begin
        if (op_reg == OP_DIV && mb_reg == '0)
            res_val = (ma_reg == '0) ? '0 : (a[DataW-1] ? SMin : SMax);
        else if (op_reg == OP_SQRT && (a[DataW-1] || a == '0))
            res_val = '0;
        else
            res_val = signed_res;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            AU_IDLE:
            begin
                if (req.start)
                begin
                    op_reg   <= req.op;
                    neg_reg  <= a[DataW-1] ^ b[DataW-1];
                    ma_reg   <= mag_a;
                    mb_reg   <= mag_b;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    root_reg <= '0;
                    if (req.op == OP_MUL)
                    begin
                        acc_reg <= '0;
                        cnt_reg <= CntW'(DataW - 1);
                    end
                    else if (req.op == OP_DIV)
                    begin
                        acc_reg <= {mag_a, {DataW{1'b0}}} >> (DataW - FRAC_BITS);
                        cnt_reg <= CntW'(NumW - 1);
                    end
                    else
                    begin
                        acc_reg <= {a, {DataW{1'b0}}} >> (DataW - FRAC_BITS);
                        cnt_reg <= CntW'(DataW - 1);
                        neg_reg <= 1'b0;
                    end
                end
            end
            AU_RUN:
            begin
                cnt_reg <= cnt_reg - 1'b1;
                case (op_reg)
                    OP_MUL:
                    begin
                        acc_reg <= mul_add[NumW:1];
                        mb_reg  <= mb_reg >> 1;
                    end
                    OP_DIV:
                    begin
                        acc_reg <= acc_reg << 1;
                        quo_reg <= {quo_reg[NumW-2:0], ~div_trial[DataW]};
                        rem_reg <= div_trial[DataW] ? {1'b0, div_sh[DataW:0]} :
                                                      {2'b00, div_trial[DataW-1:0]};
                    end
                    default:
                    begin
                        acc_reg  <= acc_reg << 2;
                        root_reg <= {root_reg[DataW-2:0], ~sq_trial[DataW+1]};
                        rem_reg  <= sq_trial[DataW+1] ? sq_sh : sq_trial;
                    end
                endcase
            end
            AU_DONE: ;
            default: ;
        endcase
    end

    assign done   = (state_reg == AU_DONE);
    assign result = res_val;

    property p_idle_after_done;
        @(posedge clk) disable iff (!rst_n) (state_reg == AU_DONE) |=> (state_reg == AU_IDLE);
    endproperty
    a_idle_after_done: assert property (p_idle_after_done) else $error("alu done not one beat");

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg == AU_RUN) |=> (state_reg != AU_IDLE);
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("alu left run early");

    property p_done_from_run;
        @(posedge clk) disable iff (!rst_n) $rose(done) |-> $past(state_reg) == AU_RUN;
    endproperty
    a_done_from_run: assert property (p_done_from_run) else $error("alu done without run");

endmodule
`default_nettype wire
